>>> design/pse_pkg.sv
// shared types and codes of the postfix stack evaluator
`default_nettype none
package pse_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned DepthW  = 7;
  localparam int unsigned StatusW = 2;

  localparam logic [CmdW-1:0] CMD_PUSH = 3'd0;
  localparam logic [CmdW-1:0] CMD_ADD  = 3'd1;
  localparam logic [CmdW-1:0] CMD_MUL  = 3'd2;
  localparam logic [CmdW-1:0] CMD_SUB  = 3'd3;
  localparam logic [CmdW-1:0] CMD_POP  = 3'd4;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]         command;
    logic signed [WordW-1:0] number;
  } in_word_t;

  typedef struct packed {
    logic signed [WordW-1:0] top_value;
    logic [DepthW-1:0]       stack_depth;
    logic [StatusW-1:0]      status;
  } out_word_t;

endpackage
`default_nettype wire

>>> design/pse_alu.sv
// wrapping add, multiply and subtract on the two top stack entries
`default_nettype none
module pse_alu (
  input  logic [pse_pkg::CmdW-1:0]  op_i,
  input  logic [pse_pkg::WordW-1:0] second_i,
  input  logic [pse_pkg::WordW-1:0] top_i,
  output logic [pse_pkg::WordW-1:0] result_o
);
  import pse_pkg::*;

  always_comb begin
    unique case (op_i)
      CMD_ADD: result_o = second_i + top_i;
      CMD_MUL: result_o = second_i * top_i;
      CMD_SUB: result_o = second_i - top_i;
      default: result_o = top_i;
    endcase
  end

endmodule
`default_nettype wire

>>> design/pse_ram.sv
// spill memory for stack entries below the two top registers
`default_nettype none
module pse_ram #(
  parameter int unsigned Depth = 62,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> design/postfix_stack_evaluator.sv
// top level of the postfix stack evaluator
//
// channel   direction  handshake                      word
// command   in         start_i high while busy_o low  in_word_i  (command, number)
// result    out        done_o strobe, one cycle        out_word_o (top_value, stack_depth, status)
//
// one word accepted per cycle; busy_o never rises
// each result leaves through the input register, then the result register
// top two entries sit in registers, the rest in a spill memory with registered read
// the entry below those two is kept ready each cycle through the memory read port plus a bypass
// reset clears depth, the bypass flag and strobes only; no clearing pass over the memory
// results are strobed, the receiver cannot stall
`default_nettype none
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  pse_pkg::in_word_t   in_word_i,
  output logic                done_o,
  output pse_pkg::out_word_t  out_word_o
);
  import pse_pkg::*;

  // spill memory holds entries 0 .. depth-3
  localparam int unsigned MemDepth = (STACK_DEPTH > 3) ? STACK_DEPTH - 2 : 1;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned DW       = $clog2(STACK_DEPTH + 1);

  // input register
  logic      in_valid_q;
  in_word_t  in_q;

  // stack state
  logic [DW-1:0]    depth_q, depth_d;
  logic [WordW-1:0] top_q, top_d;
  logic [WordW-1:0] second_q, second_d;

  // third entry: bypass of a word just spilled, else memory read data
  logic             byp_q, byp_d;
  logic [WordW-1:0] byp_data_q;
  logic [WordW-1:0] mem_rdata;
  logic [WordW-1:0] third;

  // result register
  logic      done_q;
  out_word_t out_q, out_d;

  logic             is_push, is_op, is_pop;
  logic             push_ok, op_ok, pop_ok;
  logic [WordW-1:0] alu_result;
  logic [WordW-1:0] value;
  logic [DW-1:0]    waddr_full, raddr_full;
  logic             mem_we;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q <= in_word_i;
    end
  end

  // decode of the registered command word
  assign is_push = in_valid_q && (in_q.command == CMD_PUSH);
  assign is_pop  = in_valid_q && (in_q.command == CMD_POP);
  assign is_op   = in_valid_q && ((in_q.command == CMD_ADD) || (in_q.command == CMD_MUL)
                                  || (in_q.command == CMD_SUB));

  assign push_ok = is_push && (depth_q < DW'(STACK_DEPTH));
  assign op_ok   = is_op && (depth_q >= DW'(2));
  assign pop_ok  = is_pop && (depth_q != '0);

  assign third = byp_q ? byp_data_q : mem_rdata;

  pse_alu u_alu (
    .op_i     (in_q.command),
    .second_i (second_q),
    .top_i    (top_q),
    .result_o (alu_result)
  );

  always_comb begin
    depth_d  = depth_q;
    top_d    = top_q;
    second_d = second_q;
    if (push_ok) begin
      depth_d  = depth_q + DW'(1);
      top_d    = in_q.number;
      second_d = top_q;
    end else if (op_ok) begin
      depth_d  = depth_q - DW'(1);
      top_d    = alu_result;
      second_d = third;
    end else if (pop_ok) begin
      depth_d  = depth_q - DW'(1);
      top_d    = second_q;
      second_d = third;
    end
  end

  // spill the old second entry on a push over two or more entries
  assign mem_we     = push_ok && (depth_q >= DW'(2));
  assign waddr_full = depth_q - DW'(2);
  // keep the entry below the new second entry ready for the next word
  assign raddr_full = depth_d - DW'(3);
  assign byp_d      = push_ok;

  pse_ram #(
    .Depth (MemDepth),
    .AddrW (AddrW),
    .DataW (WordW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr_full[AddrW-1:0]),
    .wdata_i (second_q),
    .raddr_i (raddr_full[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  // result word: popped value, else new top, zero when empty
  always_comb begin
    if (pop_ok) begin
      value = top_q;
    end else if (depth_d == '0) begin
      value = '0;
    end else begin
      value = top_d;
    end
    out_d.top_value   = value;
    out_d.stack_depth = DepthW'(depth_d);
    if ((is_op && !op_ok) || (is_pop && !pop_ok)) begin
      out_d.status = ST_UNDERFLOW;
    end else if (is_push && !push_ok) begin
      out_d.status = ST_OVERFLOW;
    end else begin
      out_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      byp_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      depth_q <= depth_d;
      byp_q   <= byp_d;
      done_q  <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    second_q   <= second_d;
    byp_data_q <= second_q;
    if (in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign done_o     = done_q;
  assign out_word_o = out_q;

  // every accepted word gives one result, through the input and result registers
  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start_i, 2))
    else $error("result strobe does not match accepted command words");

  // depth never exceeds the stack size
  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // an overflow leaves the stack full
  a_overflow_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (out_word_o.status == ST_OVERFLOW)) |-> (depth_q == DW'(STACK_DEPTH)))
    else $error("overflow reported on a stack that is not full");

  // an underflow only happens with fewer than two entries
  a_underflow_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (out_word_o.status == ST_UNDERFLOW)) |-> (depth_q < DW'(2)))
    else $error("underflow reported with two or more entries");

endmodule
`default_nettype wire
